FILE: rtl/lab_to_lch_polar_top_macros.svh
// assertion macros for the lab to lch converter checker
`ifndef LAB_TO_LCH_POLAR_TOP_MACROS_SVH
`define LAB_TO_LCH_POLAR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LCHP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a fixed delay between cause and effect
`define LCHP_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: rtl/lchp_pkg.sv
// shared types, constants and arctangent table of the lab to lch converter
`timescale 1ns / 1ps
`default_nettype none
package lchp_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int STAGES_MAX = 24;

	// widths of fields and datapath
	localparam int LW = 15;
	localparam int CW = 16;
	localparam int WRW = 4;
	localparam int GUARD_BITS = 14;
	localparam int XW = 33;
	localparam int ZW = 26;
	localparam int ZUW = 25;

	// angle constants in 2^-16 degree units, HUE_TURN in 1/128 degree units
	localparam logic signed [ZW-1:0] ANG_HALF_TURN = 26'sd11796480;
	localparam logic [ZUW-1:0] ANG_FULL_TURN = 25'd23592960;
	localparam logic [16:0] HUE_TURN = 17'd46080;

	// inverse cordic gain in Q0.32
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam int CHROMA_SHIFT = 32 + GUARD_BITS;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_vec_t;

	typedef struct packed {
		logic zero;
		logic [LW-1:0] lightness;
		logic [WRW-1:0] wref;
	} lch_side_t;

	// atan(2^-i) in 2^-16 degree units, rounded to nearest
	function automatic logic [21:0] atan_entry(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0: r = 22'd2949120;
			5'd1: r = 22'd1740967;
			5'd2: r = 22'd919879;
			5'd3: r = 22'd466945;
			5'd4: r = 22'd234379;
			5'd5: r = 22'd117304;
			5'd6: r = 22'd58666;
			5'd7: r = 22'd29335;
			5'd8: r = 22'd14668;
			5'd9: r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			5'd22: r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lab_to_lch_polar_top.sv
// top level of the lab to lch converter: pre-rotation, cordic cell chain, output stage
// Converts one CIELAB pixel per clock into L, chroma and hue. A request is taken whenever
// start is high; busy is always low, so a new pixel may follow in every cycle. Each pixel
// passes one input register, one cordic cell per stage and two output stages for the gain
// multiply and the rounding, and comes out in the order taken, as one cycle of done with
// the fields beside it. The receiver cannot stall the block and must take every result in
// the cycle that done is high.
`timescale 1ns / 1ps
`default_nettype none
module lab_to_lch_polar_top
	import lchp_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [LW-1:0] lightness,
	input wire logic signed [15:0] a_component,
	input wire logic signed [15:0] b_component,
	input wire logic [WRW-1:0] white_ref_id,
	output logic done,
	output logic [LW-1:0] lightness_out,
	output logic [CW-1:0] chroma,
	output logic [CW-1:0] hue,
	output logic [WRW-1:0] white_ref_out
);

	logic chain_valid [0:CORDIC_STAGES];
	cordic_vec_t chain_vec [0:CORDIC_STAGES];
	lch_side_t chain_side [0:CORDIC_STAGES];

	// the pipeline never refuses a request
	assign busy = 1'b0;

	lchp_prerot u_prerot (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (start),
		.lightness (lightness),
		.a_component (a_component),
		.b_component (b_component),
		.white_ref_id (white_ref_id),
		.out_valid (chain_valid[0]),
		.out_vec (chain_vec[0]),
		.out_side (chain_side[0])
	);

	// row of cordic cells
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		lchp_cell #(
			.STAGE (i)
		) u_cell (
			.clk (clk),
			.arst_n (arst_n),
			.in_valid (chain_valid[i]),
			.in_vec (chain_vec[i]),
			.in_side (chain_side[i]),
			.out_valid (chain_valid[i+1]),
			.out_vec (chain_vec[i+1]),
			.out_side (chain_side[i+1])
		);
	end

	lchp_post u_post (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (chain_valid[CORDIC_STAGES]),
		.in_vec (chain_vec[CORDIC_STAGES]),
		.in_side (chain_side[CORDIC_STAGES]),
		.done (done),
		.lightness_out (lightness_out),
		.chroma (chroma),
		.hue (hue),
		.white_ref_out (white_ref_out)
	);

endmodule
`default_nettype wire

FILE: rtl/lchp_prerot.sv
// input register with the half-turn pre-rotation into the right half plane
`timescale 1ns / 1ps
`default_nettype none
module lchp_prerot
	import lchp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [LW-1:0] lightness,
	input wire logic signed [15:0] a_component,
	input wire logic signed [15:0] b_component,
	input wire logic [WRW-1:0] white_ref_id,
	output logic out_valid,
	output cordic_vec_t out_vec,
	output lch_side_t out_side
);

	logic signed [XW-1:0] a_ext;
	logic signed [XW-1:0] b_ext;
	logic a_neg;
	cordic_vec_t vec_d;

	// sign extend and scale by the guard bits; negation is exact at this width
	always_comb begin
		a_ext = XW'(a_component);
		b_ext = XW'(b_component);
		a_neg = a_component[15];
		if (a_neg) begin
			vec_d.x = (-a_ext) <<< GUARD_BITS;
			vec_d.y = (-b_ext) <<< GUARD_BITS;
			vec_d.z = ANG_HALF_TURN;
		end else begin
			vec_d.x = a_ext <<< GUARD_BITS;
			vec_d.y = b_ext <<< GUARD_BITS;
			vec_d.z = '0;
		end
	end

	// request valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		out_vec <= vec_d;
		out_side.zero <= (a_component == 16'sd0) && (b_component == 16'sd0);
		out_side.lightness <= lightness;
		out_side.wref <= white_ref_id;
	end

endmodule
`default_nettype wire

FILE: rtl/lchp_cell.sv
// one vectoring cordic micro-rotation with its fixed shift and angle
`timescale 1ns / 1ps
`default_nettype none
module lchp_cell
	import lchp_pkg::*;
#(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input cordic_vec_t in_vec,
	input lch_side_t in_side,
	output logic out_valid,
	output cordic_vec_t out_vec,
	output lch_side_t out_side
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(5'(STAGE)));

	logic signed [XW-1:0] x_in;
	logic signed [XW-1:0] y_in;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	cordic_vec_t vec_d;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		x_in = in_vec.x;
		y_in = in_vec.y;
		xs = x_in >>> STAGE;
		ys = y_in >>> STAGE;
		if (!y_in[XW-1]) begin
			vec_d.x = x_in + ys;
			vec_d.y = y_in - xs;
			vec_d.z = in_vec.z + ATAN;
		end else begin
			vec_d.x = x_in - ys;
			vec_d.y = y_in + xs;
			vec_d.z = in_vec.z - ATAN;
		end
	end

	// request valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// payload handed to the next cell
	always_ff @(posedge clk) begin
		out_vec <= vec_d;
		out_side <= in_side;
	end

endmodule
`default_nettype wire

FILE: rtl/lchp_post.sv
// gain correction, hue wrap and rounding, output registers
`timescale 1ns / 1ps
`default_nettype none
module lchp_post
	import lchp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input cordic_vec_t in_vec,
	input lch_side_t in_side,
	output logic done,
	output logic [LW-1:0] lightness_out,
	output logic [CW-1:0] chroma,
	output logic [CW-1:0] hue,
	output logic [WRW-1:0] white_ref_out
);

	logic valid_s1;
	logic [63:0] prod_s1;
	logic [ZUW-1:0] zw_s1;
	lch_side_t side_s1;
	logic [ZUW-1:0] zw_d;
	logic [63:0] prod_rnd;
	logic [17:0] chroma_full;
	logic [ZUW:0] hue_sum;
	logic [16:0] hue_full;
	logic [CW-1:0] chroma_d;
	logic [CW-1:0] hue_d;

	// bring a negative angle into one turn
	always_comb begin
		if (in_vec.z[ZW-1]) begin
			zw_d = ZUW'(in_vec.z) + ANG_FULL_TURN;
		end else begin
			zw_d = ZUW'(in_vec.z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			done <= valid_s1;
		end
	end

	// x is never negative and stays below 2^31
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(in_vec.x[31:0]) * 64'(INV_GAIN_Q32);
		zw_s1 <= zw_d;
		side_s1 <= in_side;
	end

	// round half up, saturate chroma, wrap a hue of a full turn to zero, zero both for a zero vector
	always_comb begin
		prod_rnd = prod_s1 + (64'd1 << (CHROMA_SHIFT - 1));
		chroma_full = 18'(prod_rnd >> CHROMA_SHIFT);
		hue_sum = {1'b0, zw_s1} + (ZUW + 1)'(256);
		hue_full = hue_sum[ZUW:9];
		if (chroma_full > 18'd65535) begin
			chroma_d = 16'hffff;
		end else begin
			chroma_d = chroma_full[CW-1:0];
		end
		if (hue_full >= HUE_TURN) begin
			hue_d = '0;
		end else begin
			hue_d = hue_full[CW-1:0];
		end
		if (side_s1.zero) begin
			chroma_d = '0;
			hue_d = '0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		lightness_out <= side_s1.lightness;
		chroma <= chroma_d;
		hue <= hue_d;
		white_ref_out <= side_s1.wref;
	end

endmodule
`default_nettype wire

FILE: rtl/lchp_checker.sv
// port-level checker for the lab to lch converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "lab_to_lch_polar_top_macros.svh"
module lchp_checker
	import lchp_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [LW-1:0] lightness,
	input wire logic signed [15:0] a_component,
	input wire logic signed [15:0] b_component,
	input wire logic done,
	input wire logic [LW-1:0] lightness_out,
	input wire logic [CW-1:0] chroma,
	input wire logic [CW-1:0] hue
);

	localparam int LAT = CORDIC_STAGES + 3;

	logic zero_req;

	// request carries the zero vector
	assign zero_req = (a_component == 16'sd0) && (b_component == 16'sd0);

	// every request yields a result after the fixed latency
	`LCHP_ASSERT_DLY(a_req_done, start && !busy, LAT, done, "request without result")

	// no result without a request at the matching cycle
	`LCHP_ASSERT_IMP(a_done_req, done, $past(start && !busy, LAT), "result without request")

	// lightness travels with its own request
	`LCHP_ASSERT_IMP(a_l_pass, done, lightness_out == $past(lightness, LAT), "lightness mismatch")

	// zero vector gives zero chroma and hue, and hue stays below a full turn
	`LCHP_ASSERT_IMP(a_zero_vec, done && $past(zero_req, LAT), chroma == '0 && hue == '0, "zero vec")
	`LCHP_ASSERT_IMP(a_hue_rng, done, hue < 16'd46080, "hue out of range")

endmodule

bind lab_to_lch_polar_top lchp_checker #(
	.CORDIC_STAGES (CORDIC_STAGES)
) u_lchp_checker (
	.clk (clk),
	.arst_n (arst_n),
	.start (start),
	.busy (busy),
	.lightness (lightness),
	.a_component (a_component),
	.b_component (b_component),
	.done (done),
	.lightness_out (lightness_out),
	.chroma (chroma),
	.hue (hue)
);
`default_nettype wire

FILE: tb/lab_to_lch_polar_top_tb.sv
// self-checking testbench for the lab to lch converter with its own cordic predictor
`timescale 1ns / 1ps
`default_nettype none
module lab_to_lch_polar_top_tb
	import lchp_pkg::*;
();

	typedef longint unsigned u64_t;

	// one converted pixel as it leaves the block
	typedef struct packed {
		logic [LW-1:0] lightness;
		logic [CW-1:0] chroma;
		logic [CW-1:0] hue;
		logic [WRW-1:0] wref;
	} lch_pixel_t;

	// one row of the directed table; known rows carry their result typed in
	typedef struct packed {
		logic [LW-1:0] l;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic [WRW-1:0] w;
		logic known;
		logic [CW-1:0] chroma;
		logic [CW-1:0] hue;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_PER_PHASE = 267;
	localparam int DRAIN_CYCLES = CORDIC_STAGES_DEF + 20;
	localparam longint GUARD_SCALE = longint'(1) << GUARD_BITS;
	localparam longint FULL_TURN = longint'(ANG_FULL_TURN);
	localparam longint HALF_TURN = longint'(ANG_HALF_TURN);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [LW-1:0] lightness;
	logic signed [15:0] a_component;
	logic signed [15:0] b_component;
	logic [WRW-1:0] white_ref_id;
	logic done;
	logic [LW-1:0] lightness_out;
	logic [CW-1:0] chroma;
	logic [CW-1:0] hue;
	logic [WRW-1:0] white_ref_out;

	lch_pixel_t pending_lch[$];
	int mismatches = 0;
	int results_seen = 0;
	int directed_sent = 0;
	int random_sent = 0;

	// atan(2^-i) in 2^-16 degree units
	longint arctan_step [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// zero vectors, pass-through limits, axes, extremes and the hue wrap near 360
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{0, 0, 0, 0, 1, 0, 0},
		'{25600, 0, 0, 15, 1, 0, 0},
		'{32767, 0, 0, 5, 1, 0, 0},
		'{12800, 256, 0, 1, 0, 0, 0},
		'{12800, -256, 0, 2, 0, 0, 0},
		'{12800, 0, 256, 3, 0, 0, 0},
		'{12800, 0, -256, 4, 0, 0, 0},
		'{0, 32767, 0, 6, 0, 0, 0},
		'{25600, -32768, 0, 7, 0, 0, 0},
		'{100, 0, -32768, 8, 0, 0, 0},
		'{200, 0, 32767, 9, 0, 0, 0},
		'{300, -32768, -32768, 10, 0, 0, 0},
		'{400, 32767, 32767, 11, 0, 0, 0},
		'{500, -32768, 32767, 12, 0, 0, 0},
		'{600, 32767, -32768, 13, 0, 0, 0},
		'{16384, 1, 0, 14, 0, 0, 0},
		'{16383, -1, 0, 15, 0, 0, 0},
		'{1, 1, 1, 0, 0, 0, 0},
		'{2, -1, -1, 0, 0, 0, 0},
		'{21845, 32767, -1, 10, 0, 0, 0},
		'{10922, 20000, -3, 5, 0, 0, 0},
		'{4, 0, 1, 3, 0, 0, 0},
		'{32767, -5, 32767, 15, 0, 0, 0}
	};

	lab_to_lch_polar_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lightness(lightness),
		.a_component(a_component),
		.b_component(b_component),
		.white_ref_id(white_ref_id),
		.done(done),
		.lightness_out(lightness_out),
		.chroma(chroma),
		.hue(hue),
		.white_ref_out(white_ref_out)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// vectoring cordic: magnitude and angle of (a, b), then gain and hue rounding
	function automatic lch_pixel_t convert_lab_pixel(input logic [LW-1:0] l,
		input logic signed [15:0] a, input logic signed [15:0] b, input logic [WRW-1:0] w);
		lch_pixel_t r;
		longint px;
		longint py;
		longint pz;
		longint xs;
		longint ys;
		u64_t prod;
		u64_t mag;
		u64_t ang;
		int i;
		r.lightness = l;
		r.wref = w;
		r.chroma = '0;
		r.hue = '0;
		if (a != 0 || b != 0) begin
			// fold the left half plane onto the right one
			if (a < 0) begin
				px = -longint'(a) * GUARD_SCALE;
				py = -longint'(b) * GUARD_SCALE;
				pz = HALF_TURN;
			end else begin
				px = longint'(a) * GUARD_SCALE;
				py = longint'(b) * GUARD_SCALE;
				pz = 0;
			end
			for (i = 0; i < CORDIC_STAGES_DEF && i < STAGES_MAX; i++) begin
				xs = px >>> i;
				ys = py >>> i;
				if (py >= 0) begin
					px = px + ys;
					py = py - xs;
					pz = pz + arctan_step[i];
				end else begin
					px = px - ys;
					py = py + xs;
					pz = pz - arctan_step[i];
				end
			end
			// remove cordic gain, round half up, saturate
			if (px < 0)
				px = 0;
			prod = u64_t'(px) * u64_t'(INV_GAIN_Q32);
			mag = (prod + (u64_t'(1) << (CHROMA_SHIFT - 1))) >> CHROMA_SHIFT;
			if (mag > 65535)
				mag = 65535;
			// wrap angle into one turn, round to 1/128 degree
			while (pz < 0)
				pz = pz + FULL_TURN;
			while (pz >= FULL_TURN)
				pz = pz - FULL_TURN;
			ang = (u64_t'(pz) + 256) >> 9;
			if (ang >= u64_t'(HUE_TURN))
				ang = ang - u64_t'(HUE_TURN);
			r.chroma = mag[CW-1:0];
			r.hue = ang[CW-1:0];
		end
		return r;
	endfunction

	// values at and next to the ends of the a and b range, and around zero
	function automatic logic signed [15:0] pick_edge_value();
		case ($urandom_range(0, 6))
			0: return -16'sd32768;
			1: return -16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			5: return 16'sd32766;
			default: return 16'sd32767;
		endcase
	endfunction

	// present one request and hold it until taken; queue what it must produce
	task automatic send_pixel(input logic [LW-1:0] l, input logic signed [15:0] a,
		input logic signed [15:0] b, input logic [WRW-1:0] w, input lch_pixel_t want);
		start <= 1'b1;
		lightness <= l;
		a_component <= a;
		b_component <= b;
		white_ref_id <= w;
		do
			@(posedge clk);
		while (!(start && !busy));
		pending_lch.push_back(want);
	endtask

	// sender idles one cycle at a time, each cycle with the given chance
	task automatic rest_sender(input int gap_pct);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// result checker: every done cycle must match the oldest outstanding request
	always @(posedge clk) begin
		lch_pixel_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_lch.size() == 0) begin
				$display("%0t: stray result, expected none, actual L=%0d C=%0d h=%0d w=%0d",
					$time, lightness_out, chroma, hue, white_ref_out);
				mismatches++;
			end else begin
				want = pending_lch.pop_front();
				check_field("lightness_out", 32'(want.lightness), 32'(lightness_out));
				check_field("chroma", 32'(want.chroma), 32'(chroma));
				check_field("hue", 32'(want.hue), 32'(hue));
				check_field("white_ref_out", 32'(want.wref), 32'(white_ref_out));
			end
		end
	end

	// stimulus
	initial begin
		int row;
		int phase;
		int gap_pct;
		logic [LW-1:0] pix_l;
		logic signed [15:0] pix_a;
		logic signed [15:0] pix_b;
		logic signed [15:0] mag_v;
		logic [WRW-1:0] pix_w;
		lch_pixel_t want;
		arst_n <= 1'b0;
		start <= 1'b0;
		lightness <= '0;
		a_component <= '0;
		b_component <= '0;
		white_ref_id <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_rows[row].known)
				want = '{directed_rows[row].l, directed_rows[row].chroma,
					directed_rows[row].hue, directed_rows[row].w};
			else
				want = convert_lab_pixel(directed_rows[row].l, directed_rows[row].a,
					directed_rows[row].b, directed_rows[row].w);
			send_pixel(directed_rows[row].l, directed_rows[row].a, directed_rows[row].b,
				directed_rows[row].w, want);
			directed_sent++;
			rest_sender(19);
		end

		// random pixels under three sender gap profiles
		for (phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 19 : (phase == 1) ? 64 : 0;
			repeat (RANDOM_PER_PHASE) begin
				pix_l = ($urandom_range(0, 4) != 0) ? LW'($urandom_range(0, 25600))
					: LW'($urandom_range(0, 32767));
				pix_w = WRW'($urandom_range(0, 15));
				case ($urandom_range(0, 9))
					// small magnitudes around the origin
					4, 5: begin
						pix_a = 16'($urandom_range(0, 1024) - 512);
						pix_b = 16'($urandom_range(0, 1024) - 512);
					end
					// on an axis, zero vector included
					6: begin
						pix_a = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom_range(0, 65535));
						pix_b = (pix_a == 0) ? 16'($urandom_range(0, 65535)) : 16'sd0;
						if ($urandom_range(0, 7) == 0)
							pix_b = 16'sd0;
					end
					7: begin
						pix_a = pick_edge_value();
						pix_b = pick_edge_value();
					end
					// just below the positive a axis, where hue wraps near 360
					8: begin
						pix_a = 16'($urandom_range(1, 32767));
						pix_b = -16'($urandom_range(0, 8));
					end
					// diagonals
					9: begin
						mag_v = 16'($urandom_range(1, 32767));
						pix_a = $urandom_range(0, 1) ? mag_v : -mag_v;
						pix_b = $urandom_range(0, 1) ? mag_v : -mag_v;
					end
					default: begin
						pix_a = 16'($urandom_range(0, 65535));
						pix_b = 16'($urandom_range(0, 65535));
					end
				endcase
				send_pixel(pix_l, pix_a, pix_b, pix_w,
					convert_lab_pixel(pix_l, pix_a, pix_b, pix_w));
				random_sent++;
				rest_sender(gap_pct);
			end
		end
		start <= 1'b0;

		// drain the pipeline
		while (pending_lch.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d directed and %0d random pixels, sender gaps 19, 64, 0 percent",
			directed_sent, random_sent);
		$display("%0d results checked, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("run limit reached with %0d requests outstanding", pending_lch.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
